// ===== rtl/dgt_pkg.sv =====
`default_nettype none

package dgt_pkg;

    localparam int DEPTH_W     = 16;
    localparam int IDX_W       = 20;
    localparam int CFG_WIDTH_W = 11;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 64;

    localparam logic [CFG_INDEX_W-1:0] REG_FRAME_WIDTH     = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_DEPTH_THRESHOLD = 1'b1;

    localparam logic [CFG_WIDTH_W-1:0] FRAME_WIDTH_RESET     = 11'd640;
    localparam logic [DEPTH_W-1:0]     DEPTH_THRESHOLD_RESET = 16'd0;

    typedef struct packed {
        logic [IDX_W-1:0] vertex_first;
        logic [IDX_W-1:0] vertex_second;
        logic [IDX_W-1:0] vertex_third;
        logic             last;
    } t_tri;

endpackage

`default_nettype wire

// ===== rtl/dgt_ram.sv =====
`default_nettype none

module dgt_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  wire                      i_clk,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_waddr,
    input  wire  [WIDTH-1:0]         i_wdata,
    input  wire                      i_re,
    input  wire  [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/depth_grid_triangulation.sv =====
`default_nettype none
// An accepted pixel is registered into stage 1 (r_s1_*), its triangles then into r_o.
// One pixel per cycle while m_axis_tready is high and it yields at most one triangle;
// two triangles stall input until r_p drains; output issues at most one triangle per cycle.
// Reset (synchronous, active low) clears position counters, held depths and output valids,
// and loads the register defaults; the line buffer RAM is not cleared.

module depth_grid_triangulation
    import dgt_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_cfg_we,
    input  wire  [CFG_INDEX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0]   i_cfg_data,
    input  wire                     s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire  [IN_TDATA_W-1:0]   s_axis_tdata,   // [15:0] depth
    input  wire                     s_axis_tuser,   // [0] start_of_frame
    output logic                    m_axis_tvalid,
    input  wire                     m_axis_tready,
    // [19:0] vertex_first, [39:20] vertex_second, [59:40] vertex_third, [63:60] zero
    output logic [OUT_TDATA_W-1:0]  m_axis_tdata,
    output logic                    m_axis_tlast
);

    localparam int CW = $clog2(MAX_WIDTH);
    localparam int WW = $clog2(MAX_WIDTH + 1);
    localparam int RW = $clog2(MAX_HEIGHT + 1);
    localparam int EW = (WW > CFG_WIDTH_W) ? WW : CFG_WIDTH_W;
    localparam logic [EW-1:0] MAX_W_E  = EW'(MAX_WIDTH);
    localparam logic [RW-1:0] MAX_H_R  = RW'(MAX_HEIGHT);

    logic [CFG_WIDTH_W-1:0] r_frame_width;
    logic [DEPTH_W-1:0]     r_threshold;

    logic [CW-1:0]    r_col;
    logic [RW-1:0]    r_row;
    logic [IDX_W-1:0] r_pix;
    logic [DEPTH_W-1:0] r_left;
    logic [DEPTH_W-1:0] r_ul;

    logic               r_s1_valid;
    logic               r_s1_cell;
    logic [IDX_W-1:0]   r_s1_br;
    logic [WW-1:0]      r_s1_w;
    logic [DEPTH_W-1:0] r_s1_left;
    logic [DEPTH_W-1:0] r_s1_d;

    logic r_o_valid;
    t_tri r_o;
    logic r_p_valid;
    t_tri r_p;

    logic [EW-1:0]      fw_ext;
    logic [WW-1:0]      eff_w;
    logic               in_acc;
    logic [CW-1:0]      x;
    logic [RW-1:0]      y;
    logic [IDX_W-1:0]   pix;
    logic [CW-1:0]      n_col;
    logic [RW-1:0]      n_row;
    logic [DEPTH_W-1:0] up;
    logic               out_free;
    logic               s1_move;
    logic               o_take;
    logic               ur_ok;
    logic               ll_ok;
    logic               tri1_ok;
    logic               tri2_ok;
    t_tri               first_tri;
    t_tri               second_tri;

    always_comb begin
        fw_ext = EW'(r_frame_width);
        if (fw_ext < EW'(2)) begin
            eff_w = WW'(2);
        end else if (fw_ext > MAX_W_E) begin
            eff_w = WW'(MAX_WIDTH);
        end else begin
            eff_w = WW'(fw_ext);
        end
    end

    assign out_free      = !r_o_valid || (m_axis_tready && !r_p_valid);
    assign s1_move       = r_s1_valid && out_free;
    assign s_axis_tready = !r_s1_valid || s1_move;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign o_take        = r_o_valid && m_axis_tready;

    always_comb begin
        x   = s_axis_tuser ? '0 : r_col;
        y   = s_axis_tuser ? '0 : r_row;
        pix = s_axis_tuser ? '0 : r_pix;
        if ((WW'(x) + WW'(1)) >= eff_w) begin
            n_col = '0;
            n_row = (y < MAX_H_R) ? y + RW'(1) : y;
        end else begin
            n_col = x + CW'(1);
            n_row = y;
        end
    end

    dgt_ram #(
        .WIDTH (DEPTH_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_buf (
        .i_clk   (i_clk),
        .i_we    (in_acc),
        .i_waddr (x),
        .i_wdata (s_axis_tdata[DEPTH_W-1:0]),
        .i_re    (in_acc),
        .i_raddr (x),
        .o_rdata (up)
    );

    always_comb begin
        ur_ok   = up > r_threshold;
        ll_ok   = r_s1_left > r_threshold;
        tri1_ok = r_s1_cell && ((r_ul > r_threshold) || ur_ok || ll_ok);
        tri2_ok = r_s1_cell && (ur_ok || ll_ok || (r_s1_d > r_threshold));
        first_tri.vertex_first   = r_s1_br - IDX_W'(r_s1_w) - IDX_W'(1);
        first_tri.vertex_second  = r_s1_br - IDX_W'(r_s1_w);
        first_tri.vertex_third   = r_s1_br - IDX_W'(1);
        first_tri.last           = !tri2_ok;
        second_tri.vertex_first  = r_s1_br - IDX_W'(r_s1_w);
        second_tri.vertex_second = r_s1_br - IDX_W'(1);
        second_tri.vertex_third  = r_s1_br;
        second_tri.last          = 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width <= FRAME_WIDTH_RESET;
            r_threshold   <= DEPTH_THRESHOLD_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_FRAME_WIDTH:     r_frame_width <= i_cfg_data[CFG_WIDTH_W-1:0];
                REG_DEPTH_THRESHOLD: r_threshold   <= i_cfg_data[DEPTH_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_pix      <= '0;
            r_left     <= '0;
            r_ul       <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (s1_move) begin
                r_ul <= up;
            end
            if (in_acc) begin
                r_col      <= n_col;
                r_row      <= n_row;
                r_pix      <= pix + IDX_W'(1);
                r_left     <= s_axis_tdata[DEPTH_W-1:0];
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_cell <= (x != '0) && (y != '0) && (y < MAX_H_R);
            r_s1_br   <= pix;
            r_s1_w    <= eff_w;
            r_s1_left <= r_left;
            r_s1_d    <= s_axis_tdata[DEPTH_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
            r_p_valid <= 1'b0;
        end else if (s1_move && (tri1_ok || tri2_ok)) begin
            r_o_valid <= 1'b1;
            r_p_valid <= tri1_ok && tri2_ok;
        end else if (o_take) begin
            r_o_valid <= r_p_valid;
            r_p_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && (tri1_ok || tri2_ok)) begin
            r_o <= tri1_ok ? first_tri : second_tri;
            r_p <= second_tri;
        end else if (o_take) begin
            r_o <= r_p;
        end
    end

    assign m_axis_tvalid = r_o_valid;
    assign m_axis_tdata  = {(OUT_TDATA_W - 3 * IDX_W)'(0), r_o.vertex_third,
                            r_o.vertex_second, r_o.vertex_first};
    assign m_axis_tlast  = r_o.last;

endmodule

`default_nettype wire
